>>> src/isp_pkg.sv
package isp_pkg;

    // key universe is a square of a power of two, split into rows
    localparam int UNIVERSE = 256;
    localparam int MEMBER_W = $clog2(UNIVERSE);
    localparam int KEY_W    = MEMBER_W + 1;
    localparam int ROW_W    = MEMBER_W / 2;
    localparam int ROWS     = 1 << ROW_W;
    localparam int MODE_W   = 2;

    // stream widths, rounded up to whole bytes
    localparam int S_USED_W  = MODE_W + KEY_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

    // result beat layout, lowest bit first
    localparam int OUT_FOUND_LSB    = 0;
    localparam int OUT_PRED_LSB     = OUT_FOUND_LSB + 1;
    localparam int OUT_NONEMPTY_LSB = OUT_PRED_LSB + MEMBER_W;
    localparam int OUT_MIN_LSB      = OUT_NONEMPTY_LSB + 1;
    localparam int OUT_MAX_LSB      = OUT_MIN_LSB + MEMBER_W;
    localparam int OUT_USED_W       = OUT_MAX_LSB + MEMBER_W;
    localparam int M_TDATA_W        = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef logic [ROWS-1:0]     row_t;
    typedef logic [ROW_W-1:0]    idx_t;
    typedef logic [MEMBER_W-1:0] member_t;

    // index of the highest set bit, zero when none
    function automatic idx_t top_bit(input row_t v);
        idx_t r;
        r = '0;
        for (int i = 0; i < ROWS; i++) begin
            if (v[i]) r = idx_t'(i);
        end
        return r;
    endfunction

    // index of the lowest set bit, zero when none
    function automatic idx_t bottom_bit(input row_t v);
        idx_t r;
        r = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (v[i]) r = idx_t'(i);
        end
        return r;
    endfunction

    // bits strictly below position n
    function automatic row_t below_mask(input idx_t n);
        row_t m;
        for (int i = 0; i < ROWS; i++) begin
            m[i] = (idx_t'(i) < n);
        end
        return m;
    endfunction

endpackage

>>> src/integer_set_predecessor.sv
// path: an accepted beat passes the input register, then the result register
// throughput: one beat per cycle unless m_tready stalls; the row lookup and
//   priority encode are combinational between input and result registers
// reset: aresetn low (synchronous) empties the set and drops both valid flags
// every input beat yields exactly one result beat
module integer_set_predecessor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mode [1:0], key [10:2], zero pad above
    input  logic [isp_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pred_found [0], pred_key [8:1], set_nonempty [9], min_key [17:10],
    // max_key [25:18], zero pad above
    output logic [isp_pkg::M_TDATA_W-1:0] m_tdata
);
    import isp_pkg::*;

    // input register
    logic              in_valid_reg;
    mode_t             in_mode_reg;
    logic [KEY_W-1:0]  in_key_reg;

    // set state: one occupancy row per cluster, a summary bit per row,
    // cached per-row extremes and cached global extremes
    row_t    rows_reg    [ROWS];
    idx_t    row_min_reg [ROWS];
    idx_t    row_max_reg [ROWS];
    row_t    summary_reg;
    logic    occupied_reg;
    member_t least_reg;
    member_t greatest_reg;

    // result register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    logic advance;

    // decoded key
    idx_t key_hi;
    idx_t key_lo;
    logic key_out;
    row_t row_cur;
    row_t key_bit;

    // update path
    row_t    row_new;
    logic    write_en;
    row_t    summary_new;
    idx_t    top_row;
    idx_t    bot_row;
    member_t new_max;
    member_t new_min;
    logic    new_nonempty;

    // query path
    row_t    row_below;
    row_t    sum_below;
    idx_t    pred_row;
    idx_t    rm_addr;
    idx_t    rm_rd;
    idx_t    rmin_rd;

    // result fields
    logic    res_found;
    member_t res_pred;
    logic    res_nonempty;
    member_t res_min;
    member_t res_max;

    // the pipe moves when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= mode_t'(s_tdata[MODE_W-1:0]);
            in_key_reg  <= s_tdata[MODE_W +: KEY_W];
        end
    end

    // key split: row number in the high half, position in the low half;
    // the top key bit marks a key at or past the universe
    assign key_hi  = in_key_reg[MEMBER_W-1 -: ROW_W];
    assign key_lo  = in_key_reg[ROW_W-1:0];
    assign key_out = in_key_reg[MEMBER_W];
    assign row_cur = rows_reg[key_hi];
    assign key_bit = row_t'(1) << key_lo;

    // row update; duplicate insert rewrites the same value, absent remove
    // and out-of-universe keys leave the state alone
    always_comb begin
        row_new  = row_cur;
        write_en = 1'b0;
        unique case (in_mode_reg)
            MODE_INSERT: begin
                if (!key_out) begin
                    row_new  = row_cur | key_bit;
                    write_en = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (!key_out && |(row_cur & key_bit)) begin
                    row_new  = row_cur & ~key_bit;
                    write_en = 1'b1;
                end
            end
            MODE_QUERY, MODE_NOP: begin
                row_new  = row_cur;
                write_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        summary_new         = summary_reg;
        summary_new[key_hi] = |row_new;
    end

    assign top_row      = top_bit(summary_new);
    assign bot_row      = bottom_bit(summary_new);
    assign new_nonempty = |summary_new;

    // predecessor search: first inside the key's own row, then the highest
    // occupied row below it, whose cached maximum is the answer
    assign row_below = row_cur & below_mask(key_lo);
    assign sum_below = summary_reg & below_mask(key_hi);
    assign pred_row  = top_bit(sum_below);

    // one read port on the row-maximum cache, shared by query and update
    assign rm_addr = (in_mode_reg == MODE_QUERY) ? pred_row : top_row;
    assign rm_rd   = row_max_reg[rm_addr];
    assign rmin_rd = row_min_reg[bot_row];

    // new global extremes; the row just written has no cached value yet
    always_comb begin
        if (!new_nonempty) begin
            new_max = '0;
            new_min = '0;
        end else begin
            new_max = (top_row == key_hi) ? {key_hi, top_bit(row_new)} : {top_row, rm_rd};
            new_min = (bot_row == key_hi) ? {key_hi, bottom_bit(row_new)}
                                          : {bot_row, rmin_rd};
        end
    end

    always_comb begin
        res_found = 1'b0;
        res_pred  = '0;
        if (in_mode_reg == MODE_QUERY) begin
            priority if (key_out) begin
                // key at or past the universe: answer is the maximum
                res_found = occupied_reg;
                res_pred  = greatest_reg;
            end else if (|row_below) begin
                res_found = 1'b1;
                res_pred  = {key_hi, top_bit(row_below)};
            end else if (|sum_below) begin
                res_found = 1'b1;
                res_pred  = {pred_row, rm_rd};
            end else begin
                res_found = 1'b0;
                res_pred  = '0;
            end
        end
    end

    assign res_nonempty = write_en ? new_nonempty : occupied_reg;
    assign res_min      = write_en ? new_min      : least_reg;
    assign res_max      = write_en ? new_max      : greatest_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                rows_reg[r] <= '0;
            end
            summary_reg  <= '0;
            occupied_reg <= 1'b0;
            least_reg    <= '0;
            greatest_reg <= '0;
        end else if (advance && write_en) begin
            rows_reg[key_hi] <= row_new;
            summary_reg      <= summary_new;
            occupied_reg     <= new_nonempty;
            least_reg        <= new_min;
            greatest_reg     <= new_max;
        end
    end

    // per-row extremes are read only for rows the summary marks occupied
    always_ff @(posedge aclk) begin
        if (advance && write_en) begin
            row_min_reg[key_hi] <= bottom_bit(row_new);
            row_max_reg[key_hi] <= top_bit(row_new);
        end
    end

    assign out_data_next = {{(M_TDATA_W - OUT_USED_W){1'b0}},
                            res_max, res_min, res_nonempty, res_pred, res_found};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> src/isp_checker.sv
module isp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    // pred_found, pred_key, set_nonempty, min_key, max_key from bit 0 up
    input logic [isp_pkg::M_TDATA_W-1:0] m_tdata
);
    import isp_pkg::*;

    logic    found;
    member_t pred;
    logic    nonempty;
    member_t min_k;
    member_t max_k;

    assign found    = m_tdata[OUT_FOUND_LSB];
    assign pred     = m_tdata[OUT_PRED_LSB +: MEMBER_W];
    assign nonempty = m_tdata[OUT_NONEMPTY_LSB];
    assign min_k    = m_tdata[OUT_MIN_LSB +: MEMBER_W];
    assign max_k    = m_tdata[OUT_MAX_LSB +: MEMBER_W];

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a non-empty set has ordered extremes
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && nonempty |-> min_k <= max_k)
        else $error("minimum above maximum");

    // an empty set reports zero extremes and no predecessor
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !nonempty |-> min_k == '0 && max_k == '0 && !found)
        else $error("empty set with nonzero fields");

    // a found predecessor lies within the set's range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && found |-> nonempty && pred >= min_k && pred <= max_k)
        else $error("predecessor outside set range");

    // no predecessor means a zero key
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !found |-> pred == '0)
        else $error("predecessor key without a hit");

endmodule

bind integer_set_predecessor isp_checker u_isp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
